// ===== rtl/scfp_pkg.sv =====
// Shared types and constants of the sum-checked frame parser.
package scfp_pkg;

  // Byte that opens every frame.
  localparam logic [7:0] START_BYTE = 8'h3a;

  // Parse phases, one for each byte position of a frame.
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_ADDR0 = 4'd1,
    PH_ADDR1 = 4'd2,
    PH_FUNC0 = 4'd3,
    PH_FUNC1 = 4'd4,
    PH_LEN0  = 4'd5,
    PH_LEN1  = 4'd6,
    PH_DATA  = 4'd7,
    PH_CHK1  = 4'd8
  } phase_e;

  // Kinds of result item.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_FAIL    = 2'd2
  } kind_e;

  // One result item as it travels from the parser to the output register.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [15:0] addr;
    logic [15:0] func;
    logic [15:0] len;
  } result_t;

endpackage

// ===== rtl/scfp_in_stage.sv =====
// Input register that holds one received byte until the parser takes it.
module scfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // rx_byte
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       accept;

  // The register is free when empty or when its byte leaves this cycle.
  assign s_axis_tready_o = !valid_q || take_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= s_axis_tdata_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = data_q;

endmodule

// ===== rtl/scfp_parser.sv =====
// Frame parse state and the per-byte update that forms each result item.
module scfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output scfp_pkg::result_t res_o
);

  scfp_pkg::phase_e phase_q, phase_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] func_q, func_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_lo_q, chk_lo_d;
  logic        emit;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (byte_valid_i) begin
      case (phase_q)
        scfp_pkg::PH_HUNT: begin
          if (byte_i == scfp_pkg::START_BYTE) begin
            phase_d = scfp_pkg::PH_ADDR0;
          end
        end
        scfp_pkg::PH_ADDR0: phase_d = scfp_pkg::PH_ADDR1;
        scfp_pkg::PH_ADDR1: phase_d = scfp_pkg::PH_FUNC0;
        scfp_pkg::PH_FUNC0: phase_d = scfp_pkg::PH_FUNC1;
        scfp_pkg::PH_FUNC1: phase_d = scfp_pkg::PH_LEN0;
        scfp_pkg::PH_LEN0:  phase_d = scfp_pkg::PH_LEN1;
        scfp_pkg::PH_LEN1:  phase_d = scfp_pkg::PH_DATA;
        scfp_pkg::PH_DATA: begin
          if (left_q == 16'd0) begin
            phase_d = scfp_pkg::PH_CHK1;
          end
        end
        scfp_pkg::PH_CHK1:  phase_d = scfp_pkg::PH_HUNT;
        default:            phase_d = scfp_pkg::PH_HUNT;
      endcase
    end
  end

  // Header fields, payload count, running sum and the result item.
  always_comb begin
    addr_d       = addr_q;
    func_d       = func_q;
    len_d        = len_q;
    left_d       = left_q;
    sum_d        = sum_q;
    chk_lo_d     = chk_lo_q;
    emit         = 1'b0;
    res_o.kind   = scfp_pkg::KIND_PAYLOAD;
    res_o.payload = 8'd0;
    // Header fields of a result are those in force before this byte.
    res_o.addr   = addr_q;
    res_o.func   = func_q;
    res_o.len    = len_q;
    if (byte_valid_i) begin
      case (phase_q)
        scfp_pkg::PH_ADDR0: addr_d = {8'd0, byte_i};
        scfp_pkg::PH_ADDR1: addr_d = {byte_i, addr_q[7:0]};
        scfp_pkg::PH_FUNC0: func_d = {8'd0, byte_i};
        scfp_pkg::PH_FUNC1: func_d = {byte_i, func_q[7:0]};
        scfp_pkg::PH_LEN0:  len_d  = {8'd0, byte_i};
        scfp_pkg::PH_LEN1: begin
          len_d  = {byte_i, len_q[7:0]};
          left_d = {byte_i, len_q[7:0]};
          sum_d  = addr_q + func_q + {byte_i, len_q[7:0]};
        end
        scfp_pkg::PH_DATA: begin
          if (left_q == 16'd0) begin
            chk_lo_d = byte_i;
          end else begin
            sum_d         = sum_q + {8'd0, byte_i};
            left_d        = left_q - 16'd1;
            emit          = 1'b1;
            res_o.payload = byte_i;
          end
        end
        scfp_pkg::PH_CHK1: begin
          emit = 1'b1;
          if ({byte_i, chk_lo_q} == sum_q) begin
            res_o.kind = scfp_pkg::KIND_GOOD;
          end else begin
            res_o.kind = scfp_pkg::KIND_FAIL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= scfp_pkg::PH_HUNT;
      addr_q   <= 16'd0;
      func_q   <= 16'd0;
      len_q    <= 16'd0;
      left_q   <= 16'd0;
      sum_q    <= 16'd0;
      chk_lo_q <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      func_q   <= func_d;
      len_q    <= len_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
      chk_lo_q <= chk_lo_d;
    end
  end

`ifndef SYNTHESIS
  // The last check byte always sends the parser back to hunting.
  a_chk_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && phase_q == scfp_pkg::PH_CHK1 |=> phase_q == scfp_pkg::PH_HUNT)
    else $error("parser did not return to hunting after the check word");

  // Each payload item counts one byte off the remaining length.
  a_left_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && phase_q == scfp_pkg::PH_DATA && left_q != 16'd0
    |=> left_q == $past(left_q) - 16'd1)
    else $error("payload count did not step down");

  // A frame verdict carries a zero payload byte.
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != scfp_pkg::KIND_PAYLOAD |-> res_o.payload == 8'd0)
    else $error("frame verdict with nonzero payload byte");
`endif

endmodule

// ===== rtl/scfp_out_stage.sv =====
// Output register that holds one result item until the sink takes it.
module scfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  scfp_pkg::result_t res_i,
  output logic              space_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [55:0]       m_axis_tdata_o,  // payload_byte, frame_address,
                                             // function_code, payload_length
  output logic [1:0]        m_axis_tuser_o   // result_kind
);

  logic              valid_q, valid_d;
  scfp_pkg::result_t res_q;

  // Room for a new item when empty or when the held item leaves now.
  assign space_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {res_q.len, res_q.func, res_q.addr, res_q.payload};
  assign m_axis_tuser_o  = res_q.kind;

endmodule

// ===== rtl/sum_checked_frame_parser.sv =====
// Top level of the sum-checked frame parser.
//
// Takes one received byte per cycle and, once a 0x3a start byte is seen,
// gathers a little-endian address, function code and length, passes each
// payload byte out as a result item, and ends the frame with a frame good
// or checksum fail item once the 16-bit little-endian check word (sum of
// header fields and payload bytes, modulo 2^16) has arrived. Bytes between
// frames, such as CR/LF, give no result. The block sustains one byte per
// cycle while results are taken; the parse state update is the loop that
// sets this. A byte waits in the input register, and its result in the
// output register. While a result waits in the output register the parser
// stalls; the input register takes at most one more byte, and then the
// input ready stays low until the result leaves.
module sum_checked_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // payload_byte [7:0], frame_address [23:8],
                                        // function_code [39:24],
                                        // payload_length [55:40]
  output logic [1:0]  m_axis_tuser_o    // result_kind
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_space;
  logic              take;
  logic              res_valid;
  scfp_pkg::result_t res;

  // The parser takes a byte whenever the output register can take a result.
  assign take = in_valid && out_space;

  scfp_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .take_i          (take),
    .valid_o         (in_valid),
    .byte_o          (in_byte)
  );

  scfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (take),
    .byte_i       (in_byte),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  scfp_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (res_valid),
    .res_i           (res),
    .space_o         (out_space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== bench/tb_sum_checked_frame_parser.sv =====
// Testbench for the sum-checked frame parser: byte stream in, result items out.
`timescale 1ns / 100ps

module tb_sum_checked_frame_parser;

  localparam int unsigned BYTE_TARGET = 1050;
  localparam int unsigned QUIET_FROM  = 900;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Predicts the result items of the parser and checks them in order.
  class frame_scoreboard;
    scfp_pkg::phase_e  phase;
    logic [15:0]       addr;
    logic [15:0]       func;
    logic [15:0]       len;
    logic [15:0]       left;
    logic [15:0]       sum;
    logic [7:0]        chk_lo;
    scfp_pkg::result_t results_due[$];
    int unsigned       mismatches;

    function new();
      phase = scfp_pkg::PH_HUNT;
      addr = '0;
      func = '0;
      len = '0;
      left = '0;
      sum = '0;
      chk_lo = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Advances the parse state by one accepted byte.
    function void note_rx_byte(logic [7:0] b);
      scfp_pkg::result_t r;
      r = '0;
      case (phase)
        scfp_pkg::PH_HUNT: begin
          if (b == scfp_pkg::START_BYTE) phase = scfp_pkg::PH_ADDR0;
        end
        scfp_pkg::PH_ADDR0: begin
          addr = {8'h00, b};
          phase = scfp_pkg::PH_ADDR1;
        end
        scfp_pkg::PH_ADDR1: begin
          addr[15:8] = b;
          phase = scfp_pkg::PH_FUNC0;
        end
        scfp_pkg::PH_FUNC0: begin
          func = {8'h00, b};
          phase = scfp_pkg::PH_FUNC1;
        end
        scfp_pkg::PH_FUNC1: begin
          func[15:8] = b;
          phase = scfp_pkg::PH_LEN0;
        end
        scfp_pkg::PH_LEN0: begin
          len = {8'h00, b};
          phase = scfp_pkg::PH_LEN1;
        end
        scfp_pkg::PH_LEN1: begin
          len[15:8] = b;
          left = len;
          sum = addr + func + len;
          phase = scfp_pkg::PH_DATA;
        end
        scfp_pkg::PH_DATA: begin
          if (left == 16'd0) begin
            chk_lo = b;
            phase = scfp_pkg::PH_CHK1;
          end else begin
            sum = sum + {8'h00, b};
            left = left - 16'd1;
            r.kind = scfp_pkg::KIND_PAYLOAD;
            r.payload = b;
            r.addr = addr;
            r.func = func;
            r.len = len;
            results_due.insert(results_due.size(), r);
          end
        end
        scfp_pkg::PH_CHK1: begin
          phase = scfp_pkg::PH_HUNT;
          r.kind = ({b, chk_lo} == sum) ? scfp_pkg::KIND_GOOD : scfp_pkg::KIND_FAIL;
          r.payload = 8'h00;
          r.addr = addr;
          r.func = func;
          r.len = len;
          results_due.insert(results_due.size(), r);
        end
        default: phase = scfp_pkg::PH_HUNT;
      endcase
    endfunction

    // Compares one accepted result item with the oldest prediction.
    function void check_result(logic [1:0] kind, logic [55:0] data);
      scfp_pkg::result_t e;
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d data=%014h", kind, data);
        mismatches++;
        return;
      end
      e = results_due.pop_front();
      if (kind != e.kind || data[7:0] != e.payload || data[23:8] != e.addr ||
          data[39:24] != e.func || data[55:40] != e.len) begin
        if (mismatches < 10) begin
          $display("mismatch: exp kind=%0d byte=%02h addr=%04h func=%04h len=%04h",
                   e.kind, e.payload, e.addr, e.func, e.len);
          $display("          got kind=%0d byte=%02h addr=%04h func=%04h len=%04h",
                   kind, data[7:0], data[23:8], data[39:24], data[55:40]);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  frame_scoreboard sb;
  int unsigned     cycles = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     rx_stall = 0;
  bit              quiet = 1'b0;
  bit              tx_gaps = 1'b1;

  sum_checked_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_sum_checked_frame_parser: errors");
      $finish;
    end
  end

  // Result side: check accepted items and stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
      if (quiet || cycles[8]) begin
        rx_stall <= 0;
        m_axis_tready_i <= 1'b1;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        rx_stall <= $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Sends one byte, with an optional idle burst before it.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_rx_byte(b);
    bytes_sent++;
    if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  // Any byte except the start byte.
  function automatic logic [7:0] noise_byte();
    logic [8:0] v;
    v = 9'($urandom_range(0, 254));
    if (v >= {1'b0, scfp_pkg::START_BYTE}) v = v + 9'd1;
    return v[7:0];
  endfunction

  // Sends a whole frame; a nonzero check_skew corrupts the check word.
  task automatic send_frame(input logic [15:0] addr, input logic [15:0] func,
                            input logic [15:0] len, input logic [15:0] check_skew,
                            input int unsigned start_pct);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = addr + func + len;
    send_byte(scfp_pkg::START_BYTE);
    send_byte(addr[7:0]);
    send_byte(addr[15:8]);
    send_byte(func[7:0]);
    send_byte(func[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int unsigned i = 0; i < len; i++) begin
      b = ($urandom_range(0, 99) < start_pct) ? scfp_pkg::START_BYTE : 8'($urandom);
      sum = sum + {8'h00, b};
      send_byte(b);
    end
    sum = sum + check_skew;
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
  endtask

  // Waits until every predicted result has come out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    logic [15:0] addr;
    logic [15:0] func;
    logic [15:0] len;
    logic [15:0] skew;
    int unsigned pick;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: line endings and extreme noise between frames, an empty frame
    // with all-ones address and function, a start byte in the payload, a bad check.
    send_byte(8'h0d);
    send_byte(8'h0a);
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(16'hffff, 16'hffff, 16'h0000, 16'h0000, 0);
    send_byte(8'h0d);
    send_byte(8'h0a);
    send_frame(16'h3a3a, 16'h0000, 16'h0002, 16'h0001, 100);
    drain();

    // Random frames, mostly well formed, some with a bad check, some loaded
    // with start bytes, one long frame, and noise or CR/LF between frames.
    while (bytes_sent < BYTE_TARGET) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      addr = 16'($urandom);
      func = 16'($urandom);
      len = 16'($urandom_range(0, 12));
      skew = 16'h0000;
      if (pick < 20) skew = 16'($urandom_range(1, 65535));
      else if (pick < 25) skew = 16'h0100;
      if (pick >= 90) begin
        addr = {scfp_pkg::START_BYTE, 8'($urandom)};
        len = 16'($urandom_range(0, 40));
      end
      if (bytes_sent > 300 && bytes_sent < 340) len = 16'h0100;
      send_frame(addr, func, len, skew, (pick >= 80) ? 30 : 2);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'h0d);
          send_byte(8'h0a);
        end else begin
          send_byte(noise_byte());
        end
      end
      if (bytes_sent > 600 && bytes_sent < 650) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_sum_checked_frame_parser: clean");
    end else begin
      $display("tb_sum_checked_frame_parser: errors");
    end
    $finish;
  end

endmodule
